// ===== rtl/gppt_pkg.sv =====
`timescale 1ns / 1ps

package gppt_pkg;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_LOAD,
      ST_DIV,
      ST_CLAMP,
      ST_MAP,
      ST_TMO,
      ST_CMP,
      ST_OUT
   } state_type;

   // how much work a request needs after it is taken
   typedef enum logic [1:0] {
      PATH_SHORT,
      PATH_TIMED,
      PATH_AXIS
   } path_type;

   typedef struct packed {
      logic accept;
      logic scale;
      logic load_div;
      logic div_step;
      logic clamp;
      logic map;
      logic tmo;
      logic cmp;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      path_type path;
      logic     sat_zero;
      logic     out_free;
   } status_type;

   localparam logic MODE_STROBE = 1'b0;

   localparam logic [3:0] IDX_BUTTON_ZERO = 4'd1;
   localparam logic [3:0] IDX_BUTTON_ONE  = 4'd2;
   localparam logic [3:0] IDX_BUTTON_TWO  = 4'd3;
   localparam logic [3:0] IDX_AXIS_X      = 4'd4;
   localparam logic [3:0] IDX_AXIS_Y      = 4'd5;
   localparam logic [3:0] IDX_FIXED_LO    = 4'd6;
   localparam logic [3:0] IDX_FIXED_HI    = 4'd7;

   localparam int unsigned DIR_MIN_BIT = 0;
   localparam int unsigned DIR_MAX_BIT = 1;

   localparam logic CSR_DEAD_ZONE  = 1'b0;
   localparam logic CSR_SATURATION = 1'b1;

   localparam logic [4:0] DEAD_ZONE_RESET  = 5'd10;
   localparam logic [6:0] SATURATION_RESET = 7'd95;

   // axis conditioning
   localparam logic [13:0] AXIS_GAIN  = 14'd10000;
   localparam int unsigned GAIN_SHIFT = 15;
   localparam logic [6:0]  PCT_SCALE  = 7'd100;

   localparam int unsigned DIV_BITS  = 20;
   localparam int unsigned DIV_CNT_W = 5;

   localparam logic [14:0] AXIS_HALF_SPAN = 15'd10000;
   localparam logic [14:0] AXIS_MAX_MAG   = 15'd9999;
   localparam logic [14:0] AXIS_OFS_MAX   = 15'd19999;

   // (u * 256) / 20000 == (u * 8) / 625, done as a reciprocal multiply
   localparam logic [17:0] MAP_RECIP = 18'd214749;
   localparam int unsigned MAP_SHIFT = 27;

   localparam logic [7:0] PAD_MIN    = 8'd0;
   localparam logic [7:0] PAD_MAX    = 8'd255;
   localparam logic [7:0] PAD_CENTER = 8'd128;
   localparam logic [7:0] PAD_FIXED  = 8'h7F;

   // value / 86 for an 8-bit value is 0, 1 or 2
   localparam logic [7:0] PAD_STEP1    = 8'd86;
   localparam logic [7:0] PAD_STEP2    = 8'd172;
   localparam logic [3:0] TIMEOUT_BASE = 4'd10;

   localparam logic [7:0] DATA_HIGH = 8'hFF;
   localparam logic [7:0] DATA_LOW  = 8'h00;

endpackage

// ===== rtl/game_port_paddle_timer.sv =====
`timescale 1ns / 1ps

// Channel   Ports      Handshake        Contents
// request   req_*      valid / ready    access mode, index, cycle count, pad inputs
// response  rsp_*      valid / ready    read byte, floating bus flag
// csr       csr_*      write enable     dead zone (0), saturation (1)
//
// One request at a time. Strobe, button and unmapped reads go straight to the output
// register. Overridden or absent axis and index 6/7 pass through timeout and compare;
// a conditioned axis adds scale, the 20-step restoring divide for saturation scaling
// (skipped with saturation zero), clamp and map. Synchronous reset restores dead zone
// 10, saturation 95 and clears the strobe. A new request is taken while a response
// waits; a finished request holds in the sequencer until the response register is free.

module game_port_paddle_timer #(
   parameter int unsigned CYCLE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [6:0]         csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [3:0]         req_reg_index,
   input  logic [31:0]        req_clock_now,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic [1:0]         req_dir_x,
   input  logic [1:0]         req_dir_y,
   input  logic               req_pad_present,
   input  logic               req_button_zero,
   input  logic               req_button_one,
   input  logic               req_button_two,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_read_data,
   output logic               rsp_floating_bus
);

   gppt_pkg::cmd_type    cmd;
   gppt_pkg::status_type status;

   gppt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gppt_datapath #(
      .CYCLE_BITS (CYCLE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_mode         (req_mode),
      .req_reg_index    (req_reg_index),
      .req_clock_now    (req_clock_now),
      .req_axis_x       (req_axis_x),
      .req_axis_y       (req_axis_y),
      .req_dir_x        (req_dir_x),
      .req_dir_y        (req_dir_y),
      .req_pad_present  (req_pad_present),
      .req_button_zero  (req_button_zero),
      .req_button_one   (req_button_one),
      .req_button_two   (req_button_two),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_read_data    (rsp_read_data),
      .rsp_floating_bus (rsp_floating_bus)
   );

endmodule

// ===== rtl/gppt_ctrl.sv =====
`timescale 1ns / 1ps

module gppt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gppt_pkg::status_type status,
   output gppt_pkg::cmd_type    cmd
);

   gppt_pkg::state_type state_ff, state_in;
   logic [gppt_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gppt_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         gppt_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               unique case (status.path)
                  gppt_pkg::PATH_AXIS:  state_in = gppt_pkg::ST_SCALE;
                  gppt_pkg::PATH_TIMED: state_in = gppt_pkg::ST_TMO;
                  default:              state_in = gppt_pkg::ST_OUT;
               endcase
            end
         end
         gppt_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = gppt_pkg::ST_LOAD;
         end
         gppt_pkg::ST_LOAD: begin
            cmd.load_div = 1'b1;
            cnt_in       = '0;
            // zero saturation skips the scaling
            state_in     = status.sat_zero ? gppt_pkg::ST_CLAMP : gppt_pkg::ST_DIV;
         end
         gppt_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == gppt_pkg::DIV_CNT_W'(gppt_pkg::DIV_BITS - 1)) begin
               state_in = gppt_pkg::ST_CLAMP;
            end
         end
         gppt_pkg::ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = gppt_pkg::ST_MAP;
         end
         gppt_pkg::ST_MAP: begin
            cmd.map  = 1'b1;
            state_in = gppt_pkg::ST_TMO;
         end
         gppt_pkg::ST_TMO: begin
            cmd.tmo  = 1'b1;
            state_in = gppt_pkg::ST_CMP;
         end
         gppt_pkg::ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = gppt_pkg::ST_OUT;
         end
         gppt_pkg::ST_OUT: begin
            // hold until the output register is free
            cmd.out_load = status.out_free;
            if (status.out_free) begin
               state_in = gppt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gppt_pkg::ST_IDLE;
         end
      endcase
   end

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == gppt_pkg::ST_DIV |-> cnt_ff < gppt_pkg::DIV_CNT_W'(gppt_pkg::DIV_BITS))
      else $error("divide step count out of range");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != gppt_pkg::ST_IDLE)
      else $error("accepted request did not start work");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == gppt_pkg::ST_DIV && cnt_ff == gppt_pkg::DIV_CNT_W'(gppt_pkg::DIV_BITS - 1)
      |=> state_ff == gppt_pkg::ST_CLAMP)
      else $error("divide did not finish after its last step");

endmodule

// ===== rtl/gppt_datapath.sv =====
`timescale 1ns / 1ps

module gppt_datapath #(
   parameter int unsigned CYCLE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gppt_pkg::cmd_type     cmd,
   output gppt_pkg::status_type  status,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [6:0]            csr_wdata,
   input  logic                  req_mode,
   input  logic [3:0]            req_reg_index,
   input  logic [31:0]           req_clock_now,
   input  logic signed [15:0]    req_axis_x,
   input  logic signed [15:0]    req_axis_y,
   input  logic [1:0]            req_dir_x,
   input  logic [1:0]            req_dir_y,
   input  logic                  req_pad_present,
   input  logic                  req_button_zero,
   input  logic                  req_button_one,
   input  logic                  req_button_two,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_read_data,
   output logic                  rsp_floating_bus
);

   // configuration and strobe state
   logic [4:0]            dead_zone_ff;
   logic [6:0]            saturation_ff;
   logic [CYCLE_BITS-1:0] strobe_cycle_ff;
   logic                  strobe_active_ff;
   logic                  rsp_valid_ff;

   // working registers
   logic [CYCLE_BITS-1:0]   now_ff;
   logic                    neg_ff;
   logic [15:0]             mag0_ff;
   logic [13:0]             mag1_ff;
   logic [6:0]              rem_ff;
   logic [gppt_pkg::DIV_BITS-1:0] quo_ff;
   logic [14:0]             u_ff;
   logic [7:0]              r_ff;
   logic [11:0]             timeout_ff;
   logic [CYCLE_BITS-1:0]   interval_ff;
   logic [7:0]              res_data_ff;
   logic                    res_float_ff;
   logic [7:0]              rsp_read_data_ff;
   logic                    rsp_floating_bus_ff;

   // request decode
   logic [CYCLE_BITS-1:0] now_in;
   logic signed [15:0]    raw_sel;
   logic                  neg_in;
   logic [15:0]           mag0_in;
   logic [1:0]            dir_sel;
   logic [7:0]            r_direct;
   logic [7:0]            acc_data;
   logic                  acc_float;
   gppt_pkg::path_type    path;

   assign now_in  = CYCLE_BITS'(req_clock_now);
   // Y is inverted: -raw - 1 is the bitwise complement
   assign raw_sel = (req_reg_index == gppt_pkg::IDX_AXIS_Y) ? ~req_axis_y : req_axis_x;
   assign neg_in  = raw_sel[15];
   assign mag0_in = neg_in ? (16'(~raw_sel) + 16'd1) : 16'(raw_sel);
   assign dir_sel = (req_reg_index == gppt_pkg::IDX_AXIS_Y) ? req_dir_y : req_dir_x;

   always_comb begin
      priority if (dir_sel[gppt_pkg::DIR_MIN_BIT]) begin
         r_direct = gppt_pkg::PAD_MIN;
      end else if (dir_sel[gppt_pkg::DIR_MAX_BIT]) begin
         r_direct = gppt_pkg::PAD_MAX;
      end else begin
         r_direct = gppt_pkg::PAD_CENTER;
      end
   end

   always_comb begin
      path = gppt_pkg::PATH_SHORT;
      if (req_mode != gppt_pkg::MODE_STROBE) begin
         unique case (req_reg_index)
            gppt_pkg::IDX_AXIS_X, gppt_pkg::IDX_AXIS_Y: begin
               path = ((dir_sel != 2'b00) || !req_pad_present) ? gppt_pkg::PATH_TIMED
                                                               : gppt_pkg::PATH_AXIS;
            end
            gppt_pkg::IDX_FIXED_LO, gppt_pkg::IDX_FIXED_HI: path = gppt_pkg::PATH_TIMED;
            default: path = gppt_pkg::PATH_SHORT;
         endcase
      end
   end

   // immediate answer for strobes, buttons and unmapped indexes
   always_comb begin
      acc_data  = gppt_pkg::DATA_LOW;
      acc_float = 1'b0;
      if (req_mode != gppt_pkg::MODE_STROBE) begin
         unique case (req_reg_index)
            gppt_pkg::IDX_BUTTON_ZERO:
               acc_data = req_button_zero ? gppt_pkg::DATA_HIGH : gppt_pkg::DATA_LOW;
            gppt_pkg::IDX_BUTTON_ONE:
               acc_data = req_button_one ? gppt_pkg::DATA_HIGH : gppt_pkg::DATA_LOW;
            gppt_pkg::IDX_BUTTON_TWO:
               acc_data = req_button_two ? gppt_pkg::DATA_HIGH : gppt_pkg::DATA_LOW;
            gppt_pkg::IDX_AXIS_X, gppt_pkg::IDX_AXIS_Y,
            gppt_pkg::IDX_FIXED_LO, gppt_pkg::IDX_FIXED_HI: ;
            default: acc_float = 1'b1;
         endcase
      end
   end

   assign status.path     = path;
   assign status.sat_zero = (saturation_ff == 7'd0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // scale stage: |v| * 10000 / 32768, truncation on the magnitude
   logic [29:0] scale_prod;
   logic [13:0] mag1_in;
   assign scale_prod = 30'(mag0_ff) * 30'(gppt_pkg::AXIS_GAIN);
   assign mag1_in    = scale_prod[gppt_pkg::GAIN_SHIFT +: 14];

   // dividend for the saturation scaling: |v| * 100
   logic [20:0] pct_prod;
   assign pct_prod = 21'(mag1_ff) * 21'(gppt_pkg::PCT_SCALE);

   // restoring divide step by saturation
   logic [7:0] div_trial;
   logic [7:0] div_diff;
   logic       div_bit;
   assign div_trial = {rem_ff, quo_ff[gppt_pkg::DIV_BITS-1]};
   assign div_diff  = div_trial - {1'b0, saturation_ff};
   assign div_bit   = (div_trial >= {1'b0, saturation_ff});

   // dead zone, clamp and offset
   logic [11:0] dz;
   logic [gppt_pkg::DIV_BITS-1:0] q_dz;
   logic [gppt_pkg::DIV_BITS-1:0] q_lim;
   logic [14:0] q_clip;
   logic [14:0] u_in;
   always_comb begin
      dz     = 12'(dead_zone_ff) * 12'(gppt_pkg::PCT_SCALE);
      q_dz   = (quo_ff <= gppt_pkg::DIV_BITS'(dz)) ? '0 : quo_ff;
      q_lim  = neg_ff ? gppt_pkg::DIV_BITS'(gppt_pkg::AXIS_HALF_SPAN)
                      : gppt_pkg::DIV_BITS'(gppt_pkg::AXIS_MAX_MAG);
      q_clip = (q_dz > q_lim) ? 15'(q_lim) : 15'(q_dz);
      u_in   = neg_ff ? (gppt_pkg::AXIS_HALF_SPAN - q_clip)
                      : (gppt_pkg::AXIS_HALF_SPAN + q_clip);
   end

   // map to a paddle byte
   logic [35:0] map_prod;
   logic [7:0]  r_in;
   assign map_prod = 36'({u_ff, 3'b000}) * 36'(gppt_pkg::MAP_RECIP);
   assign r_in     = map_prod[gppt_pkg::MAP_SHIFT +: 8];

   // timeout and elapsed count
   logic [3:0]            tmo_mult;
   logic [11:0]           timeout_in;
   logic [CYCLE_BITS-1:0] interval_in;
   logic                  expired;
   always_comb begin
      priority if (r_ff >= gppt_pkg::PAD_STEP2) begin
         tmo_mult = gppt_pkg::TIMEOUT_BASE + 4'd2;
      end else if (r_ff >= gppt_pkg::PAD_STEP1) begin
         tmo_mult = gppt_pkg::TIMEOUT_BASE + 4'd1;
      end else begin
         tmo_mult = gppt_pkg::TIMEOUT_BASE;
      end
   end
   assign timeout_in  = 12'(r_ff) * 12'(tmo_mult);
   assign interval_in = now_ff - strobe_cycle_ff;
   assign expired     = interval_ff > CYCLE_BITS'(timeout_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff     <= gppt_pkg::DEAD_ZONE_RESET;
         saturation_ff    <= gppt_pkg::SATURATION_RESET;
         strobe_cycle_ff  <= '0;
         strobe_active_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               gppt_pkg::CSR_DEAD_ZONE:  dead_zone_ff  <= csr_wdata[4:0];
               gppt_pkg::CSR_SATURATION: saturation_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.accept && req_mode == gppt_pkg::MODE_STROBE) begin
            strobe_cycle_ff  <= now_in;
            strobe_active_ff <= 1'b1;
         end
         if (cmd.cmp && expired) begin
            strobe_active_ff <= 1'b0;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         now_ff       <= now_in;
         neg_ff       <= neg_in;
         mag0_ff      <= mag0_in;
         res_data_ff  <= acc_data;
         res_float_ff <= acc_float;
         if (req_mode != gppt_pkg::MODE_STROBE) begin
            unique case (req_reg_index)
               gppt_pkg::IDX_AXIS_X, gppt_pkg::IDX_AXIS_Y: r_ff <= r_direct;
               gppt_pkg::IDX_FIXED_LO, gppt_pkg::IDX_FIXED_HI: r_ff <= gppt_pkg::PAD_FIXED;
               default: ;
            endcase
         end
      end
      if (cmd.scale) begin
         mag1_ff <= mag1_in;
      end
      if (cmd.load_div) begin
         // zero saturation passes the gain stage straight to the clamp
         quo_ff <= status.sat_zero ? gppt_pkg::DIV_BITS'(mag1_ff)
                                   : gppt_pkg::DIV_BITS'(pct_prod);
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= div_bit ? div_diff[6:0] : div_trial[6:0];
         quo_ff <= {quo_ff[gppt_pkg::DIV_BITS-2:0], div_bit};
      end
      if (cmd.clamp) begin
         u_ff <= u_in;
      end
      if (cmd.map) begin
         r_ff <= r_in;
      end
      if (cmd.tmo) begin
         timeout_ff  <= timeout_in;
         interval_ff <= interval_in;
      end
      if (cmd.cmp) begin
         res_data_ff <= expired ? gppt_pkg::DATA_LOW : gppt_pkg::DATA_HIGH;
      end
      if (cmd.out_load) begin
         rsp_read_data_ff    <= res_data_ff;
         rsp_floating_bus_ff <= res_float_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_floating_bus = rsp_floating_bus_ff;

   a_strobe_arms: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && req_mode == gppt_pkg::MODE_STROBE |=> strobe_active_ff)
      else $error("strobe did not arm the timers");

   a_float_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_floating_bus_ff |-> rsp_read_data_ff == gppt_pkg::DATA_LOW)
      else $error("floating bus result carries data");

   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      cmd.clamp |=> u_ff <= gppt_pkg::AXIS_OFS_MAX)
      else $error("conditioned axis out of range");

endmodule

// ===== verif/game_port_reply_checker.sv =====
`timescale 1ns / 1ps

module game_port_reply_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [6:0]         csr_wdata,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_mode,
   input  logic [3:0]         req_reg_index,
   input  logic [31:0]        req_clock_now,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic [1:0]         req_dir_x,
   input  logic [1:0]         req_dir_y,
   input  logic               req_pad_present,
   input  logic               req_button_zero,
   input  logic               req_button_one,
   input  logic               req_button_two,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [7:0]         rsp_read_data,
   input  logic               rsp_floating_bus,
   output int                 mismatches,
   output int                 outstanding
);

   localparam int STICK_LOW   = -10000;
   localparam int STICK_HIGH  = 9999;
   localparam int STICK_GAIN  = 10000;
   localparam int RAW_FULL    = 32768;
   localparam int MAP_SPAN    = 20000;
   localparam int PCT         = 100;
   localparam int STEP_DIV    = 86;
   localparam int TMO_BASE    = 10;

   typedef struct packed {
      logic [7:0] read_data;
      logic       floating_bus;
   } port_reply_type;

   port_reply_type reply_q[$];

   logic [4:0]  dead_zone;
   logic [6:0]  saturation;
   logic [31:0] strobe_stamp;
   logic        timers_armed;
   int          fault_total = 0;

   task automatic report_fault(string field, int unsigned seen, int unsigned wanted);
      fault_total++;
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
               $time, field, seen, wanted);
   endtask

   // Thumbstick position in -10000..9999 after override, gain, saturation and dead zone.
   function automatic int stick_position(logic signed [15:0] raw, logic invert,
                                         logic [1:0] dir, logic pad);
      int v;
      int dz;
      // minimum wins when both override bits are set
      if (dir[gppt_pkg::DIR_MIN_BIT]) return STICK_LOW;
      if (dir[gppt_pkg::DIR_MAX_BIT]) return STICK_HIGH;
      if (!pad) return 0;
      v = invert ? -int'(raw) - 1 : int'(raw);
      v = v * STICK_GAIN / RAW_FULL;
      if (saturation != 0) v = v * PCT / int'(saturation);
      dz = int'(dead_zone) * PCT;
      if (v >= -dz && v <= dz) v = 0;
      if (v > STICK_HIGH) v = STICK_HIGH;
      else if (v < STICK_LOW) v = STICK_LOW;
      return v;
   endfunction

   function automatic logic [7:0] paddle_level(int pos);
      return 8'((pos - STICK_LOW) * 256 / MAP_SPAN);
   endfunction

   // Work out the reply to the request on the bus and advance the strobe state.
   function automatic port_reply_type answer_access();
      port_reply_type ans;
      logic [7:0]  level;
      int unsigned tmo;
      logic [31:0] elapsed;
      ans = '{read_data: gppt_pkg::DATA_LOW, floating_bus: 1'b0};
      if (req_mode == gppt_pkg::MODE_STROBE) begin
         strobe_stamp = req_clock_now;
         timers_armed = 1'b1;
         return ans;
      end
      case (req_reg_index)
         gppt_pkg::IDX_BUTTON_ZERO: begin
            ans.read_data = req_button_zero ? gppt_pkg::DATA_HIGH : gppt_pkg::DATA_LOW;
            return ans;
         end
         gppt_pkg::IDX_BUTTON_ONE: begin
            ans.read_data = req_button_one ? gppt_pkg::DATA_HIGH : gppt_pkg::DATA_LOW;
            return ans;
         end
         gppt_pkg::IDX_BUTTON_TWO: begin
            ans.read_data = req_button_two ? gppt_pkg::DATA_HIGH : gppt_pkg::DATA_LOW;
            return ans;
         end
         gppt_pkg::IDX_AXIS_X:
            level = paddle_level(stick_position(req_axis_x, 1'b0, req_dir_x,
                                                req_pad_present));
         gppt_pkg::IDX_AXIS_Y:
            level = paddle_level(stick_position(req_axis_y, 1'b1, req_dir_y,
                                                req_pad_present));
         gppt_pkg::IDX_FIXED_LO, gppt_pkg::IDX_FIXED_HI: level = gppt_pkg::PAD_FIXED;
         default: begin
            ans.floating_bus = 1'b1;
            return ans;
         end
      endcase
      tmo = int'(level) * (TMO_BASE + int'(level) / STEP_DIV);
      // modulo 2^32 difference handles the counter wrap
      elapsed = req_clock_now - strobe_stamp;
      if (elapsed > tmo) begin
         timers_armed = 1'b0;
         ans.read_data = gppt_pkg::DATA_LOW;
      end else begin
         ans.read_data = gppt_pkg::DATA_HIGH;
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      port_reply_type want;
      if (reset) begin
         dead_zone = gppt_pkg::DEAD_ZONE_RESET;
         saturation = gppt_pkg::SATURATION_RESET;
         strobe_stamp = '0;
         timers_armed = 1'b0;
         reply_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == gppt_pkg::CSR_DEAD_ZONE) dead_zone = csr_wdata[4:0];
            else saturation = csr_wdata;
         end
         if (req_valid && req_ready) reply_q.push_back(answer_access());
         if (rsp_valid && rsp_ready) begin
            if (reply_q.size() == 0) begin
               report_fault("response with no request pending", rsp_read_data, 0);
            end else begin
               want = reply_q.pop_front();
               if (rsp_read_data !== want.read_data)
                  report_fault("read_data", rsp_read_data, want.read_data);
               if (rsp_floating_bus !== want.floating_bus)
                  report_fault("floating_bus", rsp_floating_bus, want.floating_bus);
            end
         end
      end
      mismatches <= fault_total;
      outstanding <= reply_q.size();
   end

endmodule

// ===== verif/game_port_paddle_timer_tb.sv =====
`timescale 1ns / 1ps

module game_port_paddle_timer_tb;

   localparam logic MODE_READ     = ~gppt_pkg::MODE_STROBE;
   localparam int   RESET_CYCLES  = 12;
   localparam int   SETTLE_CYCLES = 32;
   localparam int   STALL_LIMIT   = 2000;
   localparam int   PHASES        = 8;
   localparam int   PHASE_ITEMS   = 235;

   typedef struct {
      logic               mode;
      logic [3:0]         reg_index;
      logic [31:0]        clock_now;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic [1:0]         dir_x;
      logic [1:0]         dir_y;
      logic               pad_present;
      logic               button_zero;
      logic               button_one;
      logic               button_two;
   } bus_access_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we;
   logic               csr_index;
   logic [6:0]         csr_wdata;
   logic               req_valid;
   logic               req_ready;
   logic               req_mode;
   logic [3:0]         req_reg_index;
   logic [31:0]        req_clock_now;
   logic signed [15:0] req_axis_x;
   logic signed [15:0] req_axis_y;
   logic [1:0]         req_dir_x;
   logic [1:0]         req_dir_y;
   logic               req_pad_present;
   logic               req_button_zero;
   logic               req_button_one;
   logic               req_button_two;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_read_data;
   logic               rsp_floating_bus;
   int                 mismatches;
   int                 outstanding;

   logic [31:0] strobe_mark = '0;
   int unsigned burst_left = 0;
   int unsigned hold_left = 0;
   int unsigned beat = 0;
   int unsigned quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   game_port_paddle_timer dut (.*);

   game_port_reply_checker reply_check (.*);

   // Receiver: the stall style rotates with bits 9:8 of the beat counter, from none to long runs.
   always @(posedge clock) begin
      logic go;
      go = 1'b1;
      beat <= beat + 1;
      if (reset) begin
         go = 1'b0;
      end else if (hold_left != 0) begin
         go = 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         case (beat[9:8])
            2'd1: if ($urandom_range(0, 3) == 0) hold_left <= $urandom_range(1, 2);
            2'd2: if ($urandom_range(0, 11) == 0) hold_left <= $urandom_range(4, 16);
            2'd3: go = ($urandom_range(0, 1) != 0);
            default: ;
         endcase
      end
      rsp_ready <= go;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic bus_access_type access(logic mode, logic [3:0] idx, logic [31:0] when);
      bus_access_type a;
      a = '{mode: mode, reg_index: idx, clock_now: when, axis_x: '0, axis_y: '0,
            dir_x: '0, dir_y: '0, pad_present: 1'b1, button_zero: 1'b0,
            button_one: 1'b0, button_two: 1'b0};
      return a;
   endfunction

   function automatic logic signed [15:0] pick_axis();
      logic signed [15:0] mag;
      mag = 16'($urandom_range(0, 8000));
      case ($urandom_range(0, 4))
         0: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
         1: return ($urandom_range(0, 1) != 0) ? mag : -mag;
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly strobe-then-read sequences timed around the paddle timeouts; some noise.
   function automatic bus_access_type random_access();
      bus_access_type a;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      a = access(MODE_READ, 4'($urandom_range(4, 7)), strobe_mark + $urandom_range(0, 3200));
      a.axis_x = pick_axis();
      a.axis_y = pick_axis();
      a.dir_x = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
      a.dir_y = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
      a.pad_present = ($urandom_range(0, 7) != 0);
      a.button_zero = 1'($urandom);
      a.button_one = 1'($urandom);
      a.button_two = 1'($urandom);
      if (pick < 18) begin
         a.mode = gppt_pkg::MODE_STROBE;
         a.reg_index = 4'($urandom);
         a.clock_now = (pick < 3) ? $urandom : strobe_mark + $urandom_range(1, 5000);
         strobe_mark = a.clock_now;
      end else if (pick < 75) begin
         a.reg_index = 4'($urandom_range(gppt_pkg::IDX_AXIS_X, gppt_pkg::IDX_FIXED_HI));
      end else if (pick < 88) begin
         a.reg_index = 4'($urandom_range(gppt_pkg::IDX_BUTTON_ZERO,
                                         gppt_pkg::IDX_BUTTON_TWO));
      end else begin
         a.reg_index = 4'($urandom);
         a.clock_now = $urandom;
      end
      return a;
   endfunction

   task automatic send_access(bus_access_type a);
      req_valid <= 1'b1;
      req_mode <= a.mode;
      req_reg_index <= a.reg_index;
      req_clock_now <= a.clock_now;
      req_axis_x <= a.axis_x;
      req_axis_y <= a.axis_y;
      req_dir_x <= a.dir_x;
      req_dir_y <= a.dir_y;
      req_pad_present <= a.pad_present;
      req_button_zero <= a.button_zero;
      req_button_one <= a.button_one;
      req_button_two <= a.button_two;
      do @(posedge clock); while (!req_ready);
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Drop valid and wait until every pending request has answered.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_thresholds(logic [4:0] dz, logic [6:0] sat);
      csr_we <= 1'b1;
      csr_index <= gppt_pkg::CSR_DEAD_ZONE;
      csr_wdata <= {2'($urandom), dz};
      @(posedge clock);
      csr_index <= gppt_pkg::CSR_SATURATION;
      csr_wdata <= sat;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      bus_access_type a;
      logic [31:0] t0;
      logic [4:0]  dz;
      logic [6:0]  sat;
      t0 = 32'hFFFF_FF00;
      csr_we <= 1'b0;
      csr_index <= gppt_pkg::CSR_DEAD_ZONE;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_mode <= gppt_pkg::MODE_STROBE;
      req_reg_index <= '0;
      req_clock_now <= '0;
      req_axis_x <= '0;
      req_axis_y <= '0;
      req_dir_x <= '0;
      req_dir_y <= '0;
      req_pad_present <= 1'b0;
      req_button_zero <= 1'b0;
      req_button_one <= 1'b0;
      req_button_two <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // buttons, each read high; button zero also read low with the other two set
      a = access(MODE_READ, gppt_pkg::IDX_BUTTON_ZERO, '0);
      a.button_zero = 1'b1;
      send_access(a);
      a.button_zero = 1'b0;
      a.button_one = 1'b1;
      a.button_two = 1'b1;
      send_access(a);
      a = access(MODE_READ, gppt_pkg::IDX_BUTTON_ONE, '0);
      a.button_one = 1'b1;
      send_access(a);
      a = access(MODE_READ, gppt_pkg::IDX_BUTTON_TWO, '0);
      a.button_two = 1'b1;
      send_access(a);
      // unmapped indexes
      send_access(access(MODE_READ, 4'd0, '1));
      a = access(MODE_READ, 4'd15, '1);
      a.button_zero = 1'b1;
      a.button_one = 1'b1;
      a.button_two = 1'b1;
      send_access(a);
      send_access(access(MODE_READ, 4'd8, '0));
      // strobe near the top of the counter so the reads below wrap
      send_access(access(gppt_pkg::MODE_STROBE, 4'd9, t0));
      send_access(access(MODE_READ, gppt_pkg::IDX_FIXED_LO, t0 + 32'd1397));
      send_access(access(MODE_READ, gppt_pkg::IDX_FIXED_HI, t0 + 32'd1398));
      a = access(MODE_READ, gppt_pkg::IDX_AXIS_X, t0);
      a.dir_x = 2'b01;
      send_access(a);
      a.clock_now = t0 + 32'd1;
      send_access(a);
      a = access(MODE_READ, gppt_pkg::IDX_AXIS_Y, t0 + 32'd3060);
      a.dir_y = 2'b10;
      send_access(a);
      a.clock_now = t0 + 32'd3061;
      send_access(a);
      a = access(MODE_READ, gppt_pkg::IDX_AXIS_X, t0 + 32'd1);
      a.dir_x = 2'b11;
      send_access(a);
      a = access(MODE_READ, gppt_pkg::IDX_AXIS_Y, t0 + 32'd1408);
      a.pad_present = 1'b0;
      send_access(a);
      a.clock_now = t0 + 32'd1409;
      send_access(a);
      // raw extremes and a reading inside the dead zone
      a = access(MODE_READ, gppt_pkg::IDX_AXIS_X, t0 + 32'd100);
      a.axis_x = 16'sh7FFF;
      send_access(a);
      a.axis_x = 16'sh8000;
      send_access(a);
      a = access(MODE_READ, gppt_pkg::IDX_AXIS_Y, t0 + 32'd100);
      a.axis_y = 16'sh8000;
      send_access(a);
      a.axis_y = 16'sh7FFF;
      send_access(a);
      a = access(MODE_READ, gppt_pkg::IDX_AXIS_X, t0 + 32'd100);
      a.axis_x = 16'sd3000;
      send_access(a);
      send_access(access(gppt_pkg::MODE_STROBE, 4'd0, '0));
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin dz = 5'd0;  sat = 7'd100; end
            1: begin dz = 5'd20; sat = 7'd50;  end
            2: begin dz = 5'd31; sat = 7'd0;   end
            3: begin dz = 5'd10; sat = 7'd127; end
            4: begin dz = 5'd0;  sat = 7'd1;   end
            5: begin dz = 5'd20; sat = 7'd100; end
            default: begin
               dz = 5'($urandom_range(0, 31));
               sat = 7'($urandom_range(0, 127));
            end
         endcase
         load_thresholds(dz, sat);
         repeat (PHASE_ITEMS) send_access(random_access());
         settle();
      end

      if (mismatches == 0 && outstanding == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
